FILE: rtl/qfm_pkg.sv
// Shared types, constants and sine table function for the quadrotor force mixer.
`default_nettype none

package qfm_pkg;

    // Field widths
    localparam int MOTOR_W   = 16;
    localparam int ANGLE_W   = 15;
    localparam int ROT_W     = 18;
    localparam int LIN_W     = 21;
    localparam int THRUST_W  = 10;
    localparam int MSUM_W    = 18;
    localparam int TRIG_W    = 16;
    localparam int SCALE_W   = THRUST_W + MSUM_W;

    // Stream payload widths, padded to whole bytes
    localparam int IN_RAW_W  = 4 * MOTOR_W + 3 * ANGLE_W;
    localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = 3 * ROT_W + 3 * LIN_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    localparam int SINE_DEPTH_DEFAULT = 1024;

    // Pipeline: stages 0..2 in the angle lanes, 3..7 in the merge
    localparam int STAGES    = 8;
    localparam int STG_PROD  = 0;
    localparam int STG_INDEX = 1;
    localparam int STG_ROM   = 2;
    localparam int STG_PAIR  = 3;
    localparam int STG_TRIPLE = 4;
    localparam int STG_DIR   = 5;
    localparam int STG_SCALE = 6;
    localparam int STG_OUT   = 7;

    localparam logic [THRUST_W-1:0] THRUST_RESET = THRUST_W'(130);
    localparam logic [LIN_W-1:0]    LIN_LIMIT    = LIN_W'(1047552);

    localparam longint unsigned INV_TWO_PI_Q32 = 64'd683565276;
    localparam longint unsigned HALF_PI_Q30    = 64'd1686629713;
    localparam longint unsigned Q30_ONE        = 64'd1073741824;

    typedef struct packed {
        logic [STAGES-1:0] en;
    } pipe_ctrl_t;

    // Sine of a Q32 turn fraction, in Q1.14: quadrant fold, Q30 Taylor series, round.
    function automatic logic signed [TRIG_W-1:0] sine_q14(input longint unsigned turn);
        logic [1:0]      quad;
        longint unsigned f;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        quad = turn[31:30];
        f    = turn & (Q30_ONE - 64'd1);
        if (quad[0]) begin
            f = Q30_ONE - f;
        end
        x    = (f * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = (term > sum) ? 64'd0 : sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = (term > sum) ? 64'd0 : sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = (term > sum) ? 64'd0 : sum - term;
        v    = (sum + 64'd32768) >> 16;
        if (v > 64'd16384) begin
            v = 64'd16384;
        end
        return quad[1] ? -$signed(TRIG_W'(v)) : $signed(TRIG_W'(v));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/quadrotor_force_mixer_top.sv
// Stage order: product, index, ROM, pair, triple, direction, scale, output.
// Throughput: one request per cycle; three angle lanes and the merge pipeline
// each advance every cycle unless the result register ahead of them is held.
// Reset (aresetn low, synchronous) empties the pipeline and sets the thrust
// scale to 130; there is no table clearing pass.
// Top level of the quadrotor force mixer.
`default_nettype none

module quadrotor_force_mixer_top import qfm_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // motor_front_a, motor_front_b, motor_rear_a, motor_rear_b,
    // roll_angle, pitch_angle, yaw_angle, zero pad
    input  wire logic [IN_W-1:0]     s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // rot_force_x, rot_force_y, rot_force_z,
    // lin_force_x, lin_force_y, lin_force_z, zero pad
    output logic [OUT_W-1:0]         m_tdata,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [THRUST_W-1:0] cfg_data
);

    logic [MOTOR_W-1:0]        motor [4];
    logic signed [ANGLE_W-1:0] angle [3];
    logic signed [TRIG_W-1:0]  sin_q14 [3];
    logic signed [TRIG_W-1:0]  cos_q14 [3];

    logic [THRUST_W-1:0] thrust_reg;
    logic [THRUST_W-1:0] thrust_next;
    logic [STAGES-1:0]   vld_reg;
    logic [STAGES-1:0]   vld_next;
    pipe_ctrl_t          ctrl;

    logic signed [ROT_W-1:0] rot_next [3];
    logic signed [ROT_W-1:0] rot_reg [STAGES][3];
    logic [MSUM_W-1:0]       msum_next;
    logic [MSUM_W-1:0]       msum_reg [STG_ROM+1];
    logic signed [LIN_W-1:0] lin_x;
    logic signed [LIN_W-1:0] lin_y;
    logic signed [LIN_W-1:0] lin_z;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            motor[i] = s_tdata[i*MOTOR_W +: MOTOR_W];
        end
        for (int i = 0; i < 3; i++) begin
            angle[i] = $signed(s_tdata[4*MOTOR_W + i*ANGLE_W +: ANGLE_W]);
        end
    end

    // Each stage loads when its output is empty or the stage after it loads
    always_comb begin
        ctrl.en[STAGES-1] = !vld_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            ctrl.en[k] = !vld_reg[k] || ctrl.en[k+1];
        end
        vld_next[0] = ctrl.en[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            vld_next[k] = ctrl.en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign s_tready  = ctrl.en[0];
    assign cfg_ready = 1'b1;
    assign thrust_next = (cfg_valid && cfg_ready) ? cfg_data : thrust_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            thrust_reg <= THRUST_RESET;
        end else begin
            vld_reg    <= vld_next;
            thrust_reg <= thrust_next;
        end
    end

    // Rotation forces and motor sum, carried alongside the angle lanes
    always_comb begin
        rot_next[0] = ROT_W'(motor[2]) + ROT_W'(motor[3]) - ROT_W'(motor[0])
                    - ROT_W'(motor[1]);
        rot_next[1] = ROT_W'(motor[1]) + ROT_W'(motor[3]) - ROT_W'(motor[0])
                    - ROT_W'(motor[2]);
        rot_next[2] = ROT_W'(motor[1]) + ROT_W'(motor[2]) - ROT_W'(motor[0])
                    - ROT_W'(motor[3]);
        msum_next   = MSUM_W'(motor[0]) + MSUM_W'(motor[1]) + MSUM_W'(motor[2])
                    + MSUM_W'(motor[3]);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[0]) begin
            rot_reg[0]  <= rot_next;
            msum_reg[0] <= msum_next;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (ctrl.en[k]) begin
                rot_reg[k] <= rot_reg[k-1];
            end
        end
        for (int k = 1; k <= STG_ROM; k++) begin
            if (ctrl.en[k]) begin
                msum_reg[k] <= msum_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        qfm_angle_lane #(
            .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
        ) u_lane (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .angle  (angle[i]),
            .sin_q14(sin_q14[i]),
            .cos_q14(cos_q14[i])
        );
    end

    qfm_merge u_merge (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .thrust   (thrust_reg),
        .msum     (msum_reg[STG_ROM]),
        .sin_roll (sin_q14[0]),
        .cos_roll (cos_q14[0]),
        .sin_pitch(sin_q14[1]),
        .cos_pitch(cos_q14[1]),
        .sin_yaw  (sin_q14[2]),
        .cos_yaw  (cos_q14[2]),
        .lin_x    (lin_x),
        .lin_y    (lin_y),
        .lin_z    (lin_z)
    );

    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = {(OUT_W - OUT_RAW_W)'(0), lin_z, lin_y, lin_x,
                       rot_reg[STAGES-1][2], rot_reg[STAGES-1][1], rot_reg[STAGES-1][0]};

endmodule

`default_nettype wire

FILE: rtl/qfm_angle_lane.sv
// One angle lane: angle to table index, then registered sine and cosine lookup.
`default_nettype none

module qfm_angle_lane import qfm_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire pipe_ctrl_t               ctrl,
    input  wire logic signed [ANGLE_W-1:0] angle,
    output logic signed [TRIG_W-1:0]      sin_q14,
    output logic signed [TRIG_W-1:0]      cos_q14
);

    localparam int IW = $clog2(SINE_TABLE_DEPTH);
    localparam int KW = 31 + IW;
    localparam int PW = ANGLE_W + KW;
    localparam longint unsigned IDX_K = INV_TWO_PI_Q32 * longint'(SINE_TABLE_DEPTH);
    localparam logic [KW-1:0] IDX_K_V = KW'(IDX_K);
    localparam logic [IW:0]   DEPTH_V = (IW + 1)'(SINE_TABLE_DEPTH);
    localparam logic [IW:0]   QUARTER_V = (IW + 1)'(SINE_TABLE_DEPTH / 4);
    localparam logic [PW-1:0] HALF_V = PW'(1) << 43;

    logic signed [TRIG_W-1:0] rom [SINE_TABLE_DEPTH];

    for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
        localparam longint unsigned TURN = (longint'(i) << 32) / SINE_TABLE_DEPTH;
        assign rom[i] = sine_q14(TURN);
    end

    logic [ANGLE_W-1:0] mag;
    logic [PW-1:0]      prod_reg;
    logic [PW-1:0]      prod_next;
    logic               neg_reg;
    logic [PW-1:0]      rnd;
    logic [IW-1:0]      mag_idx;
    logic [IW-1:0]      sidx_next;
    logic [IW:0]        csum;
    logic [IW-1:0]      cidx_next;
    logic [IW-1:0]      sidx_reg;
    logic [IW-1:0]      cidx_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;

    // Magnitude of the angle, then scale by depth / (2 pi)
    always_comb begin
        mag       = angle[ANGLE_W-1] ? ANGLE_W'(~angle + 1'b1) : ANGLE_W'(angle);
        prod_next = PW'(mag) * PW'(IDX_K_V);
    end

    // Round half up, restore the sign, form the cosine index a quarter turn ahead
    always_comb begin
        rnd     = prod_reg + HALF_V;
        mag_idx = rnd[44 +: IW];
        if (neg_reg && (mag_idx != '0)) begin
            sidx_next = IW'(DEPTH_V - {1'b0, mag_idx});
        end else begin
            sidx_next = mag_idx;
        end
        csum = {1'b0, sidx_next} + QUARTER_V;
        if (csum >= DEPTH_V) begin
            cidx_next = IW'(csum - DEPTH_V);
        end else begin
            cidx_next = IW'(csum);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[STG_PROD]) begin
            prod_reg <= prod_next;
            neg_reg  <= angle[ANGLE_W-1];
        end
        if (ctrl.en[STG_INDEX]) begin
            sidx_reg <= sidx_next;
            cidx_reg <= cidx_next;
        end
        if (ctrl.en[STG_ROM]) begin
            sin_reg <= rom[sidx_reg];
            cos_reg <= rom[cidx_reg];
        end
    end

    assign sin_q14 = sin_reg;
    assign cos_q14 = cos_reg;

endmodule

`default_nettype wire

FILE: rtl/qfm_merge.sv
// Merge stage: rotation of the thrust direction and scaling into translation forces.
`default_nettype none

module qfm_merge import qfm_pkg::*; (
    input  wire logic                      aclk,
    input  wire pipe_ctrl_t                ctrl,
    input  wire logic [THRUST_W-1:0]       thrust,
    input  wire logic [MSUM_W-1:0]         msum,
    input  wire logic signed [TRIG_W-1:0]  sin_roll,
    input  wire logic signed [TRIG_W-1:0]  cos_roll,
    input  wire logic signed [TRIG_W-1:0]  sin_pitch,
    input  wire logic signed [TRIG_W-1:0]  cos_pitch,
    input  wire logic signed [TRIG_W-1:0]  sin_yaw,
    input  wire logic signed [TRIG_W-1:0]  cos_yaw,
    output logic signed [LIN_W-1:0]        lin_x,
    output logic signed [LIN_W-1:0]        lin_y,
    output logic signed [LIN_W-1:0]        lin_z
);

    localparam int PP_W  = 30;
    localparam int TR_W  = 47;
    localparam int DIR_W = 31;
    localparam int FP_W  = 60;
    localparam int RM_W  = FP_W - 36 + 1;

    // Pair products
    logic signed [PP_W-1:0]   ss_reg;
    logic signed [PP_W-1:0]   cc_reg;
    logic signed [PP_W-1:0]   cs_reg;
    logic signed [PP_W-1:0]   ys_reg;
    logic signed [PP_W-1:0]   z_reg;
    logic signed [TRIG_W-1:0] sp_reg;
    logic signed [TRIG_W-1:0] sy_reg;
    logic [SCALE_W-1:0]       scale_reg;

    // Q42 direction terms
    logic signed [TR_W-1:0]   xr_reg;
    logic signed [TR_W-1:0]   yr_reg;
    logic signed [PP_W-1:0]   z2_reg;
    logic [SCALE_W-1:0]       scale2_reg;

    // Q28 direction (-x, -y, z)
    logic signed [DIR_W-1:0]  dir_reg [3];
    logic signed [DIR_W-1:0]  dir_next [3];
    logic [SCALE_W-1:0]       scale3_reg;

    logic signed [FP_W-1:0]   fp_reg [3];
    logic signed [FP_W-1:0]   fp_next [3];
    logic signed [LIN_W-1:0]  lin_reg [3];
    logic signed [LIN_W-1:0]  lin_next [3];

    logic signed [TR_W-1:0]   tr [2];
    logic [TR_W-1:0]          tmag [2];
    logic [TR_W-1:0]          trnd [2];
    logic [FP_W-1:0]          fmag [3];
    logic [RM_W-1:0]          frnd [3];

    // Round the Q42 terms half away from zero to Q28, and negate x and y
    always_comb begin
        tr[0] = xr_reg;
        tr[1] = yr_reg;
        for (int i = 0; i < 2; i++) begin
            tmag[i] = tr[i][TR_W-1] ? TR_W'(-tr[i]) : TR_W'(tr[i]);
            trnd[i] = (tmag[i] + TR_W'(1 << 13)) >> 14;
            dir_next[i] = tr[i][TR_W-1] ? DIR_W'(trnd[i]) : -DIR_W'(trnd[i]);
        end
        dir_next[2] = DIR_W'(z2_reg);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fp_next[i] = FP_W'($signed({1'b0, scale3_reg})) * FP_W'(dir_reg[i]);
        end
    end

    // Round by 2^36 half away from zero, then clamp to the force range
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fmag[i] = fp_reg[i][FP_W-1] ? FP_W'(-fp_reg[i]) : FP_W'(fp_reg[i]);
            frnd[i] = RM_W'((fmag[i] + (FP_W'(1) << 35)) >> 36);
            if (frnd[i] > RM_W'(LIN_LIMIT)) begin
                frnd[i] = RM_W'(LIN_LIMIT);
            end
            lin_next[i] = fp_reg[i][FP_W-1] ? -LIN_W'(frnd[i]) : LIN_W'(frnd[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[STG_PAIR]) begin
            ss_reg    <= PP_W'(sin_roll) * PP_W'(sin_yaw);
            cc_reg    <= PP_W'(cos_roll) * PP_W'(cos_yaw);
            cs_reg    <= PP_W'(cos_roll) * PP_W'(sin_pitch);
            ys_reg    <= PP_W'(cos_yaw) * PP_W'(sin_roll);
            z_reg     <= PP_W'(cos_pitch) * PP_W'(cos_roll);
            sp_reg    <= sin_pitch;
            sy_reg    <= sin_yaw;
            scale_reg <= SCALE_W'(thrust) * SCALE_W'(msum);
        end
        if (ctrl.en[STG_TRIPLE]) begin
            xr_reg     <= (TR_W'(ss_reg) <<< 14) + TR_W'(cc_reg) * TR_W'(sp_reg);
            yr_reg     <= TR_W'(cs_reg) * TR_W'(sy_reg) - (TR_W'(ys_reg) <<< 14);
            z2_reg     <= z_reg;
            scale2_reg <= scale_reg;
        end
        if (ctrl.en[STG_DIR]) begin
            dir_reg    <= dir_next;
            scale3_reg <= scale2_reg;
        end
        if (ctrl.en[STG_SCALE]) begin
            fp_reg <= fp_next;
        end
        if (ctrl.en[STG_OUT]) begin
            lin_reg <= lin_next;
        end
    end

    assign lin_x = lin_reg[0];
    assign lin_y = lin_reg[1];
    assign lin_z = lin_reg[2];

endmodule

`default_nettype wire

FILE: rtl/qfm_checker.sv
// Port-level checks for the quadrotor force mixer, bound to the top level.
`default_nettype none

module qfm_checker import qfm_pkg::*; (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [OUT_W-1:0]    m_tdata
);

    logic signed [LIN_W-1:0] lin_x;
    logic signed [LIN_W-1:0] lin_y;

    assign lin_x = $signed(m_tdata[3*ROT_W +: LIN_W]);
    assign lin_y = $signed(m_tdata[3*ROT_W + LIN_W +: LIN_W]);

    // No result may come out of a pipeline that reset just emptied
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("held result changed");

    // Pairwise differences of the rotation forces are even
    a_rot_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == m_tdata[ROT_W]) && (m_tdata[0] == m_tdata[2*ROT_W]))
        else $error("rotation forces disagree in parity");

    a_lin_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (lin_x <= $signed({1'b0, LIN_LIMIT})) && (lin_x >= -$signed({1'b0, LIN_LIMIT}))
                  && (lin_y <= $signed({1'b0, LIN_LIMIT})) && (lin_y >= -$signed({1'b0, LIN_LIMIT})))
        else $error("translation force beyond limit");

    // An empty result register never blocks a new request
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request refused with result register empty");

endmodule

bind quadrotor_force_mixer_top qfm_checker u_qfm_checker (.*);

`default_nettype wire
